// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PNM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define PNM_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/core/pnm_pkg.sv =====
// ----------------------------------------------------------------------------
// PNM decoder package
// Types, character codes and limits shared by the decoder modules.
// ----------------------------------------------------------------------------
package pnm_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int LINE_LIMIT = 255;
	localparam int DIM_W      = $clog2(MAX_DIM + 1);
	localparam int POS_W      = 12;
	localparam int TOK_W      = 16;
	localparam int DIV_STEPS  = 8;

	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_SIX   = 8'h36;

	typedef enum logic [1:0] {
		KIND_PIXEL   = 2'd0,
		KIND_HDR_ERR = 2'd1,
		KIND_TRUNC   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic [7:0]       r;
		logic [7:0]       g;
		logic [7:0]       b;
		logic             last;
	} res_t;

endpackage

// ===== rtl/core/pnm_div.sv =====
// ----------------------------------------------------------------------------
// PNM sample divider
// Restoring divider giving an 8-bit quotient, saturated at 255, one bit a cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pnm_div import pnm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] numer,
	input  logic [15:0] denom,
	output logic        done,
	output logic [7:0]  quot
);

	logic        busy_q, ovf_q, done_q;
	logic [15:0] rem_q, den_q;
	logic [7:0]  low_q, q_q;
	logic [3:0]  cnt_q;
	logic [16:0] trial;
	logic        borrow;

	assign borrow = {rem_q, low_q[7]} < {1'b0, den_q};
	assign trial  = {rem_q, low_q[7]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(DIV_STEPS);
			end else if (busy_q) begin
				if (ovf_q || cnt_q == 4'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	// Datapath: a numerator whose upper part reaches the divisor overflows 8 bits.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer[23:8];
			low_q <= numer[7:0];
			den_q <= denom;
			ovf_q <= numer[23:8] >= denom;
			q_q   <= '0;
		end else if (busy_q) begin
			if (ovf_q) begin
				q_q <= 8'hFF;
			end else begin
				rem_q <= borrow ? {rem_q[14:0], low_q[7]} : trial[15:0];
				low_q <= {low_q[6:0], 1'b0};
				q_q   <= {q_q[6:0], ~borrow};
			end
		end
	end

	assign done = done_q;
	assign quot = q_q;

	`PNM_ASSERT(a_div_no_restart, start |-> !busy_q, "divider restarted while busy")
	`PNM_ASSERT(a_div_done_pulse, done_q |=> !done_q, "divider done held high")

endmodule

// ===== rtl/core/pnm_out_buf.sv =====
// ----------------------------------------------------------------------------
// PNM result buffer
// Two-entry queue holding the results of one byte for the output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pnm_out_buf import pnm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  res_t             res,
	output logic             empty,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       kind,
	output logic [POS_W-1:0] pos_x,
	output logic [POS_W-1:0] pos_y,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic             end_mark
);

	res_t       ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       pop;
	res_t       head;

	assign pop  = out_valid && out_ready;
	assign head = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= res;
	end

	assign empty     = cnt_q == 2'd0;
	assign out_valid = !empty;
	assign kind      = head.kind;
	assign pos_x     = head.x;
	assign pos_y     = head.y;
	assign red       = head.r;
	assign green     = head.g;
	assign blue      = head.b;
	assign end_mark  = head.last;

	`PNM_NEVER(a_buf_overflow, push && cnt_q == 2'd2, "result pushed into a full buffer")
	`PNM_NEVER(a_buf_count, cnt_q == 2'd3, "result count out of range")

endmodule

// ===== rtl/core/pnm_image_decoder_top.sv =====
// ----------------------------------------------------------------------------
// PNM image decoder, top level
// Byte-serial netpbm P1..P6 parser with a shared divider for sample scaling.
// ----------------------------------------------------------------------------
// The decoder takes a PNM file one byte per input transaction and returns
// pixel, header error and truncation results as output transactions. One
// byte is processed at a time and in_ready stays low until every result it
// caused has been taken. A graymap or pixmap sample goes through a start
// step that launches the shared restoring divider, a wait step while it
// forms sample*255/maxval one quotient bit a cycle and signals completion,
// and a sample step that stores the level. A quotient that would pass 255
// is caught on the first divider step, which ends the division early.
// Bitmap samples bypass the divider. A byte marked final adds three closing
// steps. That final byte closes any pending line or token, may add a pixel,
// header error or truncation result, and returns the decoder to its reset
// state for the next file. Each byte gives at most two results, held in a
// small queue in front of the output port.
`include "assert_macros.svh"

module pnm_image_decoder_top import pnm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       data_byte,
	input  logic             final_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       kind,
	output logic [POS_W-1:0] pos_x,
	output logic [POS_W-1:0] pos_y,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic             end_mark
);

	// Sequencer steps for one byte.
	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_PARSE  = 9'b000000010,
		S_DIVGO  = 9'b000000100,
		S_DIV    = 9'b000001000,
		S_SAMPLE = 9'b000010000,
		S_FIN    = 9'b000100000,
		S_FIN2   = 9'b001000000,
		S_TRUNC  = 9'b010000000,
		S_EMIT   = 9'b100000000
	} seq_t;

	// Parsing phase of the file.
	typedef enum logic [5:0] {
		PH_MAGIC = 6'b000001,
		PH_SIZE  = 6'b000010,
		PH_MAXV  = 6'b000100,
		PH_DATA  = 6'b001000,
		PH_DONE  = 6'b010000,
		PH_ERROR = 6'b100000
	} phase_t;

	seq_t             st_q;
	phase_t           phase_q;
	logic [7:0]       byte_q;
	logic             fin_q, in_fin_q;
	logic             ascii_q, cmt_q, tok_open_q;
	logic [1:0]       map_q, ci_q;
	logic [DIM_W-1:0] w_q, h_q;
	logic [TOK_W-1:0] maxl_q, tok_q, samp_q;
	logic [POS_W-1:0] col_q, row_q;
	logic [7:0]       held_q [2];
	logic [7:0]       llen_q;
	logic             push_q;
	res_t             res_q;

	logic             buf_empty;
	logic             div_start, div_done;
	logic [7:0]       div_quot;
	logic [23:0]      div_numer;

	// Byte classification for the parse step.
	logic             is_hdr, is_text, is_digit, pos0;
	logic             p_eol, p_tb, p_cmtstart, p_body, p_magic, p_digit, p_close, p_raw;
	logic             magic_err, do_eol, eol_live, do_ct, p_samp;
	logic [3:0]       digit;
	logic [19:0]      tok_next;
	logic [DIM_W-1:0] tok_dim;

	// Field values after a token is closed, and outcome of ending a line.
	logic [DIM_W-1:0] ct_w, ct_h;
	logic [1:0]       ct_ci;
	logic [TOK_W-1:0] ct_maxl;
	logic             el_err, el_enter, el_size_bad;
	phase_t           el_phase;
	logic [1:0]       el_ci;
	logic [TOK_W-1:0] el_maxl;

	// Sample completion.
	logic [7:0]       level;
	logic             need3, hold_comp, last_px, wrap;

	assign in_ready = st_q == S_IDLE;

	assign is_hdr   = phase_q == PH_MAGIC || phase_q == PH_SIZE || phase_q == PH_MAXV;
	assign is_text  = is_hdr || (phase_q == PH_DATA && ascii_q);
	assign is_digit = byte_q >= CH_ZERO && byte_q <= CH_NINE;
	assign pos0     = llen_q == 8'd0;
	assign digit    = 4'(byte_q - CH_ZERO);

	assign p_eol      = st_q == S_PARSE && is_text && byte_q == CH_LF;
	assign p_tb       = st_q == S_PARSE && is_text && byte_q != CH_LF
		&& llen_q < 8'(LINE_LIMIT);
	assign p_cmtstart = p_tb && pos0 && byte_q == CH_HASH;
	assign p_body     = p_tb && !p_cmtstart && !cmt_q;
	assign p_magic    = p_body && phase_q == PH_MAGIC;
	assign magic_err  = p_magic && ((pos0 && byte_q != CH_P)
		|| (llen_q == 8'd1 && (byte_q < CH_ONE || byte_q > CH_SIX)));
	assign p_digit    = p_body && phase_q != PH_MAGIC && is_digit;
	assign p_close    = p_body && phase_q != PH_MAGIC && !is_digit;
	assign p_raw      = st_q == S_PARSE && phase_q == PH_DATA && !ascii_q;

	// A line ends on a newline byte, or on the final byte while a non-empty header line is open.
	assign do_eol   = p_eol || (st_q == S_FIN && is_hdr && !pos0);
	assign eol_live = do_eol && !cmt_q;
	assign do_ct    = (p_close || eol_live) && tok_open_q;
	assign p_samp   = p_raw || (do_ct && phase_q == PH_DATA);

	assign tok_next = ({4'b0, tok_q} << 3) + ({4'b0, tok_q} << 1) + {16'b0, digit};
	assign tok_dim  = (tok_q > TOK_W'((1 << DIM_W) - 1)) ? DIM_W'((1 << DIM_W) - 1)
		: tok_q[DIM_W-1:0];

	always_comb begin
		ct_w    = w_q;
		ct_h    = h_q;
		ct_ci   = ci_q;
		ct_maxl = maxl_q;
		if (tok_open_q) begin
			if (phase_q == PH_SIZE && ci_q == 2'd0) begin
				ct_w  = tok_dim;
				ct_ci = 2'd1;
			end else if (phase_q == PH_SIZE && ci_q == 2'd1) begin
				ct_h  = tok_dim;
				ct_ci = 2'd2;
			end else if (phase_q == PH_MAXV && ci_q == 2'd0) begin
				ct_maxl = tok_q;
				ct_ci   = 2'd1;
			end
		end
	end

	assign el_size_bad = ct_ci < 2'd2 || ct_w == '0 || ct_w > DIM_W'(MAX_DIM)
		|| ct_h == '0 || ct_h > DIM_W'(MAX_DIM);

	always_comb begin
		el_err   = 1'b0;
		el_enter = 1'b0;
		el_phase = phase_q;
		el_ci    = ct_ci;
		el_maxl  = ct_maxl;
		unique case (phase_q)
			PH_MAGIC: begin
				if (llen_q < 8'd2) begin
					el_err = 1'b1;
				end else begin
					el_phase = PH_SIZE;
					el_ci    = 2'd0;
				end
			end
			PH_SIZE: begin
				if (el_size_bad) begin
					el_err = 1'b1;
				end else if (map_q == 2'd0) begin
					el_enter = 1'b1;
				end else begin
					el_phase = PH_MAXV;
					el_ci    = 2'd0;
					el_maxl  = '0;
				end
			end
			PH_MAXV: begin
				if (ct_ci == 2'd0 || ct_maxl == '0) el_err = 1'b1;
				else el_enter = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Scaled level: bitmaps are black or white, other maps use the divider.
	assign div_start = st_q == S_DIVGO;
	assign div_numer = {samp_q, 8'b0} - {8'b0, samp_q};
	assign level     = (map_q == 2'd0) ? {8{|samp_q}} : div_quot;
	assign need3     = map_q == 2'd2;
	assign hold_comp = need3 && ci_q < 2'd2;
	assign last_px   = {1'b0, col_q} + 13'd1 >= w_q && {1'b0, row_q} + 13'd1 >= h_q;
	assign wrap      = {1'b0, col_q} + 13'd1 >= w_q;

	pnm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.numer  (div_numer),
		.denom  (maxl_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			phase_q    <= PH_MAGIC;
			byte_q     <= '0;
			fin_q      <= 1'b0;
			in_fin_q   <= 1'b0;
			ascii_q    <= 1'b0;
			map_q      <= '0;
			w_q        <= '0;
			h_q        <= '0;
			maxl_q     <= TOK_W'(1);
			tok_q      <= '0;
			samp_q     <= '0;
			tok_open_q <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			ci_q       <= '0;
			held_q[0]  <= '0;
			held_q[1]  <= '0;
			llen_q     <= '0;
			cmt_q      <= 1'b0;
			push_q     <= 1'b0;
			res_q      <= '0;
		end else begin
			push_q <= 1'b0;

			// Token close and line end, shared by the parse and final steps.
			if (do_ct) begin
				tok_open_q <= 1'b0;
				tok_q      <= '0;
				w_q        <= ct_w;
				h_q        <= ct_h;
				ci_q       <= ct_ci;
				maxl_q     <= ct_maxl;
				if (phase_q == PH_DATA) samp_q <= tok_q;
			end
			if (eol_live) begin
				phase_q <= el_phase;
				ci_q    <= el_ci;
				maxl_q  <= el_maxl;
				if (el_enter) begin
					phase_q <= PH_DATA;
					ci_q    <= '0;
					col_q   <= '0;
					row_q   <= '0;
				end
				if (el_err) begin
					phase_q <= PH_ERROR;
					push_q  <= 1'b1;
					res_q   <= '{KIND_HDR_ERR, '0, '0, '0, '0, '0, 1'b1};
				end
			end
			if (do_eol) begin
				llen_q     <= '0;
				cmt_q      <= 1'b0;
				tok_open_q <= 1'b0;
				tok_q      <= '0;
			end

			unique case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						byte_q <= data_byte;
						fin_q  <= final_byte;
						st_q   <= S_PARSE;
					end
				end
				S_PARSE: begin
					if (p_tb) llen_q <= llen_q + 8'd1;
					if (p_cmtstart) cmt_q <= 1'b1;
					if (p_magic && llen_q == 8'd1 && !magic_err) begin
						ascii_q <= byte_q < CH_ZERO + 8'd4;
						map_q   <= (byte_q < CH_ZERO + 8'd4) ? 2'(byte_q - CH_ONE)
							: 2'(byte_q - CH_ZERO - 8'd4);
					end
					if (magic_err) begin
						phase_q <= PH_ERROR;
						push_q  <= 1'b1;
						res_q   <= '{KIND_HDR_ERR, '0, '0, '0, '0, '0, 1'b1};
					end
					if (p_digit) begin
						tok_q      <= (tok_next > 20'd65535) ? TOK_W'(16'hFFFF)
							: tok_next[TOK_W-1:0];
						tok_open_q <= 1'b1;
					end
					if (p_raw) samp_q <= {8'b0, byte_q};
					priority if (p_samp) st_q <= (map_q == 2'd0) ? S_SAMPLE : S_DIVGO;
					else if (fin_q)      st_q <= S_FIN;
					else                 st_q <= S_EMIT;
				end
				S_DIVGO: begin
					st_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) st_q <= S_SAMPLE;
				end
				S_SAMPLE: begin
					if (hold_comp) begin
						held_q[ci_q[0]] <= level;
						ci_q            <= ci_q + 2'd1;
					end else begin
						push_q <= 1'b1;
						res_q  <= '{KIND_PIXEL, col_q, row_q,
							need3 ? held_q[0] : level,
							need3 ? held_q[1] : level,
							level, last_px};
						ci_q   <= '0;
						if (last_px) begin
							phase_q <= PH_DONE;
						end else begin
							col_q <= wrap ? '0 : col_q + POS_W'(1);
							if (wrap) row_q <= row_q + POS_W'(1);
						end
					end
					priority if (in_fin_q) st_q <= S_TRUNC;
					else if (fin_q)        st_q <= S_FIN;
					else                   st_q <= S_EMIT;
				end
				S_FIN: begin
					// An open header always ends in an error unless the data begin.
					if (is_hdr && !(eol_live && (el_err || el_enter))) begin
						phase_q <= PH_ERROR;
						push_q  <= 1'b1;
						res_q   <= '{KIND_HDR_ERR, '0, '0, '0, '0, '0, 1'b1};
					end
					st_q <= S_FIN2;
				end
				S_FIN2: begin
					if (phase_q == PH_DATA && ascii_q && tok_open_q && !cmt_q) begin
						tok_open_q <= 1'b0;
						tok_q      <= '0;
						samp_q     <= tok_q;
						in_fin_q   <= 1'b1;
						st_q       <= (map_q == 2'd0) ? S_SAMPLE : S_DIVGO;
					end else begin
						st_q <= S_TRUNC;
					end
				end
				S_TRUNC: begin
					if (phase_q == PH_DATA) begin
						push_q <= 1'b1;
						res_q  <= '{KIND_TRUNC, col_q, row_q, '0, '0, '0, 1'b1};
					end
					// Back to the reset state for the next file.
					phase_q    <= PH_MAGIC;
					fin_q      <= 1'b0;
					in_fin_q   <= 1'b0;
					ascii_q    <= 1'b0;
					map_q      <= '0;
					w_q        <= '0;
					h_q        <= '0;
					maxl_q     <= TOK_W'(1);
					tok_q      <= '0;
					tok_open_q <= 1'b0;
					col_q      <= '0;
					row_q      <= '0;
					ci_q       <= '0;
					held_q[0]  <= '0;
					held_q[1]  <= '0;
					llen_q     <= '0;
					cmt_q      <= 1'b0;
					st_q       <= S_EMIT;
				end
				S_EMIT: begin
					if (!push_q && buf_empty) st_q <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	pnm_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_q),
		.res       (res_q),
		.empty     (buf_empty),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.end_mark  (end_mark)
	);

	`PNM_ASSERT(a_idle_drained, in_ready |-> !out_valid, "new byte taken with results pending")
	`PNM_ASSERT(a_div_in_wait, div_done |-> st_q == S_DIV, "divider result outside wait step")
	`PNM_NEVER(a_no_push_idle, push_q && st_q == S_IDLE, "result pushed while idle")

endmodule
